// File: hdl/chsel_pkg.sv
// Package for the channel selector with scan unit.
// Holds field widths, defaults, register indexes, beat types and the switch decoder.
// No dependencies.
`default_nettype none

package chsel_pkg;

	localparam int CHAN_W     = 7;
	localparam int POS_W      = 4;
	localparam int CODE_W     = 8;
	localparam int SW_W       = 5;
	localparam int LEVEL_W    = 10;
	localparam int DWELL_W    = 16;
	localparam int RETUNE_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int NUM_CHANNELS_DEF = 80;
	localparam int RETUNE_TICKS_DEF = 40;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = 10'd500;
	localparam logic [DWELL_W-1:0] DWELL_HIT_RST  = 16'd5000;
	localparam logic [DWELL_W-1:0] DWELL_MISS_RST = 16'd50;

	localparam logic [CHAN_W-1:0] CHAN_FIRST = 7'd1;
	localparam logic [POS_W-1:0]  POS_NONE   = 4'd0;
	localparam logic [POS_W-1:0]  POS_FIRST  = 4'd1;
	localparam logic [POS_W-1:0]  POS_SECOND = 4'd2;
	localparam logic [POS_W-1:0]  POS_LAST   = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_CHANNEL = 2'd0,
		CFG_THRESHOLD     = 2'd1,
		CFG_DWELL_HIT     = 2'd2,
		CFG_DWELL_MISS    = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef struct packed {
		logic               operation;
		logic               strobe_active;
		logic [SW_W-1:0]    switch_code;
		logic               scan_on;
		logic [LEVEL_W-1:0] signal_level;
		logic [CHAN_W-1:0]  table_index;
		logic [CODE_W-1:0]  table_code;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] pll_code;
		logic [CHAN_W-1:0] channel;
		logic              tx_mute;
		logic [POS_W-1:0]  position;
	} rsp_t;

	// Selector lines to switch position; zero marks a code that is not a position.
	function automatic logic [POS_W-1:0] pos_of_code(input logic [SW_W-1:0] code);
		logic [POS_W-1:0] p;
		unique case (code)
			5'b00001: p = 4'd1;
			5'b11110: p = 4'd2;
			5'b01110: p = 4'd3;
			5'b11011: p = 4'd4;
			5'b01011: p = 4'd5;
			5'b10011: p = 4'd6;
			5'b00011: p = 4'd7;
			5'b01101: p = 4'd8;
			5'b10101: p = 4'd9;
			5'b00101: p = 4'd10;
			5'b11001: p = 4'd11;
			5'b10001: p = 4'd12;
			default:  p = POS_NONE;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: hdl/channel_selector_with_scan_unit.sv
// Two register stages: an accepted input beat is registered into stage s1 with the PLL code
// table read, then moves into the result register when that register can advance.
// Throughput: one beat per cycle while rsp_stall does not hold the result register.
// Reset: channel 1, position 1, no dwell or retune, default scan registers.
// The PLL code table reads as zero after reset through per-entry valid bits, with no
// clearing pass, so beats are accepted right after reset.
// Depends on chsel_pkg.
`default_nettype none

module channel_selector_with_scan_unit
	import chsel_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int RETUNE_TICKS = RETUNE_TICKS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp
);

	localparam int AW = $clog2(NUM_CHANNELS);
	localparam logic [CHAN_W-1:0]   CHAN_LAST = CHAN_W'(NUM_CHANNELS);
	localparam logic [RETUNE_W-1:0] RETUNE_LD = RETUNE_W'(RETUNE_TICKS);

	logic [LEVEL_W-1:0]  threshold_q;
	logic [DWELL_W-1:0]  dwell_hit_q;
	logic [DWELL_W-1:0]  dwell_miss_q;

	logic [CHAN_W-1:0]   chan_q, chan_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic                seen_q, seen_n;
	logic [DWELL_W-1:0]  dwell_q, dwell_n;
	logic                dwelling_q, dwelling_n;
	logic [RETUNE_W-1:0] retune_q, retune_n;
	logic                mute_n;

	logic [CODE_W-1:0]   mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] ent_vld_q;

	logic                accept;
	logic                s1_adv;
	logic                tbl_we;
	logic [CHAN_W-1:0]   widx_m1, ridx_m1;
	logic [AW-1:0]       waddr, raddr;
	logic [POS_W-1:0]    dec_pos, new_pos;
	logic                go_up, go_down;
	logic [CHAN_W-1:0]   chan_up, chan_down;

	logic                valid_s1;
	logic [CODE_W-1:0]   rd_s1;
	logic                fwd_s1;
	logic [CODE_W-1:0]   fwd_code_s1;
	logic                zero_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic                mute_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [CODE_W-1:0]   code_s1;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_adv;
	assign accept    = req_valid && !req_stall;

	assign chan_up   = (chan_q >= CHAN_LAST) ? CHAN_FIRST : chan_q + 7'd1;
	assign chan_down = (chan_q <= CHAN_FIRST) ? CHAN_LAST : chan_q - 7'd1;

	assign dec_pos = pos_of_code(req.switch_code);
	assign new_pos = (dec_pos == POS_NONE) ? pos_q : dec_pos;

	always_comb begin
		go_up   = 1'b0;
		go_down = 1'b0;
		if (new_pos == POS_FIRST) begin
			go_down = (pos_q == POS_SECOND);
			go_up   = (pos_q != POS_SECOND);
		end else if (new_pos == POS_LAST) begin
			go_down = (pos_q == POS_FIRST);
			go_up   = (pos_q != POS_FIRST);
		end else begin
			go_down = (new_pos < pos_q);
			go_up   = (new_pos > pos_q);
		end
	end

	always_comb begin
		chan_n     = chan_q;
		pos_n      = pos_q;
		seen_n     = seen_q;
		dwell_n    = dwell_q;
		dwelling_n = dwelling_q;
		retune_n   = retune_q;
		mute_n     = 1'b0;
		if (req.operation == OP_TICK) begin
			if (req.strobe_active) begin
				seen_n = 1'b1;
				mute_n = 1'b1;
			end else if (seen_q) begin
				if (go_up) begin
					chan_n = chan_up;
				end else if (go_down) begin
					chan_n = chan_down;
				end
				pos_n      = new_pos;
				seen_n     = 1'b0;
				dwelling_n = 1'b0;
				dwell_n    = '0;
				retune_n   = RETUNE_LD;
			end else if (retune_q != '0) begin
				retune_n = retune_q - 6'd1;
			end else if (dwelling_q) begin
				if (dwell_q == '0) begin
					dwelling_n = 1'b0;
					chan_n     = chan_up;
					retune_n   = RETUNE_LD;
				end else begin
					dwell_n = dwell_q - 16'd1;
				end
			end else if (req.scan_on) begin
				dwell_n    = (req.signal_level >= threshold_q) ? dwell_hit_q : dwell_miss_q;
				dwelling_n = 1'b1;
			end
		end
		if (retune_n != '0) begin
			mute_n = 1'b1;
		end
	end

	assign tbl_we  = accept && (req.operation == OP_LOAD) && (req.table_index >= CHAN_FIRST)
		&& (req.table_index <= CHAN_LAST);
	assign widx_m1 = req.table_index - 7'd1;
	assign waddr   = widx_m1[AW-1:0];
	assign ridx_m1 = chan_n - 7'd1;
	assign raddr   = ridx_m1[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			dwell_hit_q  <= DWELL_HIT_RST;
			dwell_miss_q <= DWELL_MISS_RST;
			chan_q       <= CHAN_FIRST;
			pos_q        <= POS_FIRST;
			seen_q       <= 1'b0;
			dwell_q      <= '0;
			dwelling_q   <= 1'b0;
			retune_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_CHANNEL: begin
					if ((cfg_data[CHAN_W-1:0] >= CHAN_FIRST)
						&& (cfg_data[CHAN_W-1:0] <= CHAN_LAST)) begin
						chan_q <= cfg_data[CHAN_W-1:0];
					end else begin
						chan_q <= CHAN_FIRST;
					end
				end
				CFG_THRESHOLD:  threshold_q  <= cfg_data[LEVEL_W-1:0];
				CFG_DWELL_HIT:  dwell_hit_q  <= cfg_data;
				CFG_DWELL_MISS: dwell_miss_q <= cfg_data;
				default: ;
			endcase
		end else if (accept) begin
			chan_q     <= chan_n;
			pos_q      <= pos_n;
			seen_q     <= seen_n;
			dwell_q    <= dwell_n;
			dwelling_q <= dwelling_n;
			retune_q   <= retune_n;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			mem[waddr] <= req.table_code;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (tbl_we) begin
			ent_vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1      <= tbl_we && (waddr == raddr);
			fwd_code_s1 <= req.table_code;
			zero_s1     <= !ent_vld_q[raddr];
			chan_s1     <= chan_n;
			mute_s1     <= mute_n;
			pos_s1      <= pos_n;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			code_s1 = fwd_code_s1;
		end else if (zero_s1) begin
			code_s1 = '0;
		end else begin
			code_s1 = rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			rsp_q.pll_code <= code_s1;
			rsp_q.channel  <= chan_s1;
			rsp_q.tx_mute  <= mute_s1;
			rsp_q.position <= pos_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: hdl/chsel_checker.sv
// Port-level checks for the channel selector with scan unit, and the bind that attaches them.
// Depends on chsel_pkg and channel_selector_with_scan_unit.
`default_nettype none

module chsel_checker
	import chsel_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  req_stall,
	input wire logic                  rsp_valid,
	input wire logic                  rsp_stall,
	input wire rsp_t                  rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result beat changed or dropped.");

	a_chan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.channel != '0)
		else $error("Result beat shows channel zero.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.position >= POS_FIRST && rsp.position <= POS_LAST)
		else $error("Result beat shows a position outside the switch range.");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("Input stalled while the result register is empty.");

endmodule

bind channel_selector_with_scan_unit chsel_checker u_chsel_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for channel_selector_with_scan_unit.
// Drives tick and table-load beats under random idling and stalls, predicts every
// result beat in a scoreboard class. Depends on chsel_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
	import chsel_pkg::*;

	localparam int NUM_CH      = NUM_CHANNELS_DEF;
	localparam int RETUNE      = RETUNE_TICKS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 3000;
	localparam int PHASE_BEATS = 370;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cur_threshold  = 500;
	bit pressure_go    = 1'b0;
	bit pressure_done  = 1'b0;

	channel_selector_with_scan_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	function automatic logic [SW_W-1:0] code_of_position(input int p);
		case (p)
			1:       return 5'b00001;
			2:       return 5'b11110;
			3:       return 5'b01110;
			4:       return 5'b11011;
			5:       return 5'b01011;
			6:       return 5'b10011;
			7:       return 5'b00011;
			8:       return 5'b01101;
			9:       return 5'b10101;
			10:      return 5'b00101;
			11:      return 5'b11001;
			default: return 5'b10001;
		endcase
	endfunction

	class selector_scoreboard;
		logic [CHAN_W-1:0]  start_reg;
		logic [LEVEL_W-1:0] threshold_reg;
		logic [DWELL_W-1:0] hit_reg;
		logic [DWELL_W-1:0] miss_reg;
		logic [CHAN_W-1:0]  chan;
		logic [POS_W-1:0]   pos;
		bit                 strobe_seen;
		bit                 dwelling;
		logic [DWELL_W-1:0] dwell_left;
		logic [RETUNE_W-1:0] retune_left;
		logic [CODE_W-1:0]  pll_table [NUM_CH];
		logic [POS_W-1:0]   pos_lut [32];
		rsp_t               expected_q [$];
		int                 errors;
		int                 checked;
		int                 loads;
		int                 releases;
		int                 scan_steps;

		function new();
			for (int c = 0; c < 32; c++) pos_lut[c] = POS_NONE;
			for (int p = 1; p <= 12; p++) pos_lut[code_of_position(p)] = POS_W'(p);
			for (int i = 0; i < NUM_CH; i++) pll_table[i] = '0;
			start_reg     = CHAN_FIRST;
			threshold_reg = THRESHOLD_RST;
			hit_reg       = DWELL_HIT_RST;
			miss_reg      = DWELL_MISS_RST;
			chan          = CHAN_FIRST;
			pos           = POS_FIRST;
			strobe_seen   = 1'b0;
			dwelling      = 1'b0;
			dwell_left    = '0;
			retune_left   = '0;
			errors        = 0;
			checked       = 0;
			loads         = 0;
			releases      = 0;
			scan_steps    = 0;
		endfunction

		function void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_START_CHANNEL: begin
					start_reg = val[CHAN_W-1:0];
					chan = (start_reg >= 1 && start_reg <= NUM_CH) ? start_reg : CHAN_FIRST;
				end
				CFG_THRESHOLD:  threshold_reg = val[LEVEL_W-1:0];
				CFG_DWELL_HIT:  hit_reg = val;
				CFG_DWELL_MISS: miss_reg = val;
			endcase
		endfunction

		function logic [CHAN_W-1:0] chan_up(input logic [CHAN_W-1:0] c);
			return (c >= NUM_CH) ? CHAN_FIRST : c + 1'b1;
		endfunction

		function logic [CHAN_W-1:0] chan_down(input logic [CHAN_W-1:0] c);
			return (c <= 1) ? CHAN_W'(NUM_CH) : c - 1'b1;
		endfunction

		function void release_switch(input logic [SW_W-1:0] code);
			logic [POS_W-1:0] p;
			p = pos_lut[code];
			if (p == POS_NONE) p = pos;
			if (p == POS_FIRST) begin
				chan = (pos == POS_SECOND) ? chan_down(chan) : chan_up(chan);
			end else if (p == POS_LAST) begin
				chan = (pos == POS_FIRST) ? chan_down(chan) : chan_up(chan);
			end else if (p < pos) begin
				chan = chan_down(chan);
			end else if (p > pos) begin
				chan = chan_up(chan);
			end
			pos         = p;
			strobe_seen = 1'b0;
			dwelling    = 1'b0;
			dwell_left  = '0;
			retune_left = RETUNE_W'(RETUNE);
			releases++;
		endfunction

		function void note_beat(input req_t b);
			rsp_t e;
			bit   mute;
			mute = 1'b0;
			if (b.operation == OP_LOAD) begin
				if (b.table_index >= 1 && b.table_index <= NUM_CH)
					pll_table[b.table_index - 1] = b.table_code;
				loads++;
			end else if (b.strobe_active) begin
				strobe_seen = 1'b1;
				mute = 1'b1;
			end else if (strobe_seen) begin
				release_switch(b.switch_code);
			end else if (retune_left != 0) begin
				retune_left--;
			end else if (dwelling) begin
				if (dwell_left == 0) begin
					dwelling    = 1'b0;
					chan        = chan_up(chan);
					retune_left = RETUNE_W'(RETUNE);
					scan_steps++;
				end else begin
					dwell_left--;
				end
			end else if (b.scan_on) begin
				dwell_left = (b.signal_level >= threshold_reg) ? hit_reg : miss_reg;
				dwelling   = 1'b1;
			end
			if (retune_left != 0) mute = 1'b1;
			e.pll_code = pll_table[chan - 1];
			e.channel  = chan;
			e.tx_mute  = mute;
			e.position = pos;
			expected_q.push_back(e);
		endfunction

		function void report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
			errors++;
		endfunction

		function void check_result(input rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.pll_code !== e.pll_code) report("pll_code", e.pll_code, got.pll_code);
			if (got.channel !== e.channel) report("channel", e.channel, got.channel);
			if (got.tx_mute !== e.tx_mute) report("tx_mute", e.tx_mute, got.tx_mute);
			if (got.position !== e.position) report("position", e.position, got.position);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	selector_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_result(rsp);
			if (req_valid && !req_stall) sb.note_beat(req);
		end
	end

	initial begin
		int hold;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !pressure_done) begin
				hold++;
				rsp_stall <= 1'b1;
				if (hold >= HOLD_CYCLES) pressure_done = 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	task automatic send_beat(input req_t b);
		bit done;
		done = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= b;
		req_valid <= 1'b1;
		while (!done) begin
			@(posedge clk);
			done = !req_stall;
			@(negedge clk);
		end
	endtask

	task automatic set_regs(input logic [CHAN_W-1:0] start, input logic [LEVEL_W-1:0] thr,
			input logic [DWELL_W-1:0] hit, input logic [DWELL_W-1:0] miss);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_CHANNEL;
		cfg_data  <= CFG_DATA_W'(start);
		@(negedge clk);
		sb.write_reg(CFG_START_CHANNEL, CFG_DATA_W'(start));
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= CFG_DATA_W'(thr);
		@(negedge clk);
		sb.write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
		cfg_index <= CFG_DWELL_HIT;
		cfg_data  <= hit;
		@(negedge clk);
		sb.write_reg(CFG_DWELL_HIT, hit);
		cfg_index <= CFG_DWELL_MISS;
		cfg_data  <= miss;
		@(negedge clk);
		sb.write_reg(CFG_DWELL_MISS, miss);
		cfg_we <= 1'b0;
		cur_threshold = int'(thr);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic req_t noise_beat();
		req_t b;
		b.operation     = 1'($urandom_range(1));
		b.strobe_active = 1'($urandom_range(1));
		b.switch_code   = SW_W'($urandom_range(31));
		b.scan_on       = 1'($urandom_range(1));
		b.signal_level  = LEVEL_W'($urandom_range(1023));
		b.table_index   = CHAN_W'($urandom_range(127));
		b.table_code    = CODE_W'($urandom_range(255));
		return b;
	endfunction

	function automatic req_t make_tick(input bit strobe, input logic [SW_W-1:0] code,
			input bit scan, input logic [LEVEL_W-1:0] level);
		req_t b;
		b = '0;
		b.operation     = OP_TICK;
		b.strobe_active = strobe;
		b.switch_code   = code;
		b.scan_on       = scan;
		b.signal_level  = level;
		return b;
	endfunction

	function automatic req_t make_load(input logic [CHAN_W-1:0] idx, input logic [CODE_W-1:0] code);
		req_t b;
		b = '0;
		b.operation   = OP_LOAD;
		b.table_index = idx;
		b.table_code  = code;
		return b;
	endfunction

	task automatic move_switch(input logic [SW_W-1:0] code);
		send_beat(make_tick(1'b1, 5'b00000, 1'b0, '0));
		send_beat(make_tick(1'b0, code, 1'b0, '0));
	endtask

	task automatic random_traffic(input int n_beats);
		int   sent;
		int   kind;
		int   len;
		req_t b;
		sent = 0;
		while (sent < n_beats) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				len = $urandom_range(4, 1);
				repeat (len) begin
					b = noise_beat();
					b.operation = OP_TICK;
					b.strobe_active = 1'b1;
					send_beat(b);
					sent++;
				end
				b = noise_beat();
				b.operation = OP_TICK;
				b.strobe_active = 1'b0;
				if ($urandom_range(9) < 8) b.switch_code = code_of_position($urandom_range(12, 1));
				send_beat(b);
				sent++;
			end else if (kind < 80) begin
				len = $urandom_range(120, 30);
				repeat (len) begin
					b = noise_beat();
					b.operation = OP_TICK;
					b.strobe_active = 1'b0;
					b.scan_on = ($urandom_range(9) != 0);
					if ($urandom_range(7) == 0) b.signal_level = LEVEL_W'(cur_threshold);
					send_beat(b);
					sent++;
				end
			end else if (kind < 92) begin
				len = $urandom_range(8, 1);
				repeat (len) begin
					b = noise_beat();
					b.operation = OP_LOAD;
					if ($urandom_range(9) != 0) b.table_index = CHAN_W'($urandom_range(NUM_CH, 1));
					send_beat(b);
					sent++;
				end
			end else begin
				send_beat(noise_beat());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		req_valid = 1'b0;
		req       = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: table edges, zero dwell with wrap, seam rules, unknown codes.
		set_regs(7'd80, 10'd1023, 16'd0, 16'd0);
		send_beat(make_load(7'd80, 8'h5A));
		send_beat(make_load(7'd1, 8'hFF));
		send_beat(make_load(7'd0, 8'hAA));
		send_beat(make_load(7'd127, 8'h55));
		send_beat(make_load(7'd81, 8'h00));
		send_beat(make_tick(1'b0, 5'b00000, 1'b1, 10'd1023));
		send_beat(make_tick(1'b0, 5'b11111, 1'b0, 10'd0));
		send_beat(make_tick(1'b1, 5'b00000, 1'b0, '0));
		send_beat(make_load(7'd2, 8'hC3) | req_t'(1'b1) << 31);
		send_beat(make_tick(1'b0, code_of_position(12), 1'b0, '0));
		move_switch(code_of_position(1));
		move_switch(code_of_position(2));
		move_switch(code_of_position(1));
		move_switch(code_of_position(1));
		move_switch(code_of_position(12));
		move_switch(code_of_position(12));
		move_switch(5'b00000);
		move_switch(5'b11111);
		move_switch(code_of_position(7));
		drain();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_regs(7'd0, 10'd0, 16'd5, 16'hFFFF);
		random_traffic(PHASE_BEATS);
		drain();

		send_idle_pct  = 57;
		recv_stall_pct = 0;
		set_regs(7'd127, 10'd512, 16'd20, 16'd2);
		pressure_go = 1'b1;
		random_traffic(PHASE_BEATS);
		drain();

		send_idle_pct  = 0;
		recv_stall_pct = 57;
		set_regs(7'd80, 10'd1023, 16'hFFFF, 16'd0);
		random_traffic(PHASE_BEATS);
		drain();

		send_idle_pct  = 21;
		recv_stall_pct = 21;
		set_regs(7'd1, 10'd500, 16'd7, 16'd1);
		random_traffic(PHASE_BEATS);
		drain();
		repeat (10) @(negedge clk);

		if (sb.pending() != 0) begin
			$display("%0t: %0d expected result beats never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("Checked %0d result beats over five register settings and four idling patterns,",
			sb.checked);
		$display("with %0d table loads, %0d switch releases and %0d scan steps; %0d errors.",
			sb.loads, sb.releases, sb.scan_steps, sb.errors);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
